@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/fhv_pkg.sv @@
`default_nettype none
package fhv_pkg;

    localparam int HEADER_BYTES = 8;

    localparam logic [7:0] MAGIC_0     = 8'h51;
    localparam logic [7:0] MAGIC_1     = 8'h46;
    localparam logic [7:0] VERSION_ONE = 8'd1;
    localparam logic [7:0] TYPE_MIN    = 8'd1;
    localparam logic [7:0] TYPE_MAX    = 8'd2;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_SHORT    = 3'd1;
    localparam t_status ST_TOO_LONG = 3'd2;
    localparam t_status ST_MAGIC    = 3'd3;
    localparam t_status ST_VERSION  = 3'd4;
    localparam t_status ST_TYPE     = 3'd5;
    localparam t_status ST_LENGTH   = 3'd6;

    // one result on its way to the output register
    typedef struct packed {
        logic        is_verdict;
        t_status     status;
        logic [1:0]  frame_type;
        logic [15:0] shard_id;
        logic [7:0]  payload_length;
        logic        zero_byte;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/fhv_payload_store.sv @@
`default_nettype none
// Two payload banks in one synchronous RAM: one write and one read port.
module fhv_payload_store #(
    parameter int DEPTH = 496,
    parameter int AW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read, so a stalled consumer keeps it
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ hdl/frame_header_validator.sv @@
`default_nettype none
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_ready    | action, data_byte, end_of_frame, read_index
// result   | out       | o_out_valid / i_out_ready  | verdict or read reply fields
//
// One item per cycle while o_in_ready is high. A result is registered in r_p1 as its
// item is accepted, beside the payload RAM read, then moves to the output register.
// The RAM takes one write and one read each cycle; frame bytes go to the
// staging bank, reads come from the committed bank, so they never collide.
// Synchronous active-low reset clears counters, header and committed values;
// the RAM needs no clearing, since a byte is read only after a good frame wrote it.
// A stalled output holds one result and one more in flight before input stalls.
`include "assert_macros.svh"
module frame_header_validator #(
    parameter int PAYLOAD_CAP = 248
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_frame,
    input  wire logic [7:0]  i_read_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_is_frame_verdict,
    output logic [2:0]       o_status,
    output logic [1:0]       o_frame_type,
    output logic [15:0]      o_shard_id,
    output logic [7:0]       o_payload_length,
    output logic [7:0]       o_payload_read_byte
);

    localparam int HB    = fhv_pkg::HEADER_BYTES;
    localparam int LIMIT = HB + PAYLOAD_CAP + 1;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam int CMPW  = (CW > 16) ? CW : 16;
    localparam int DEPTH = 2 * PAYLOAD_CAP;
    localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0]   r_count;
    logic [63:0]     r_hdr;
    logic            r_bank;
    logic [1:0]      r_held_type;
    logic [15:0]     r_held_shard;
    logic [7:0]      r_held_len;

    logic            r_p1_valid;
    fhv_pkg::t_result r_p1;
    logic            r_out_valid;
    fhv_pkg::t_result r_out;
    logic [7:0]      r_out_byte;

    logic            accept, frame_acc, read_acc, out_free, p1_move;
    logic [63:0]     n_hdr;
    logic [CW-1:0]   n_count;
    logic [CW-1:0]   pos;
    logic [CMPW-1:0] avail, declared, pos_w, ridx_w;
    fhv_pkg::t_status chk;
    logic            commit;
    logic            wr_en;
    logic [MAW-1:0]  wr_addr, rd_addr;
    logic            rd_hit;
    logic [7:0]      rd_data;
    fhv_pkg::t_result n_p1;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_p1_valid || out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign frame_acc  = accept && (i_action == fhv_pkg::ACT_FRAME);
    assign read_acc   = accept && (i_action == fhv_pkg::ACT_READ);
    assign p1_move    = r_p1_valid && out_free;

    // absorb the byte, then check against the updated header and count
    always_comb begin
        n_hdr   = (r_count < CW'(HB)) ? {r_hdr[55:0], i_data_byte} : r_hdr;
        n_count = (r_count < CW'(LIMIT)) ? r_count + CW'(1) : r_count;
        avail    = CMPW'(n_count) - CMPW'(HB);
        declared = CMPW'(n_hdr[31:16]);
        priority if (n_count < CW'(HB)) begin
            chk = fhv_pkg::ST_SHORT;
        end else if (avail > CMPW'(PAYLOAD_CAP)) begin
            chk = fhv_pkg::ST_TOO_LONG;
        end else if (n_hdr[63:56] != fhv_pkg::MAGIC_0 || n_hdr[55:48] != fhv_pkg::MAGIC_1) begin
            chk = fhv_pkg::ST_MAGIC;
        end else if (n_hdr[47:40] != fhv_pkg::VERSION_ONE) begin
            chk = fhv_pkg::ST_VERSION;
        end else if (n_hdr[39:32] < fhv_pkg::TYPE_MIN || n_hdr[39:32] > fhv_pkg::TYPE_MAX) begin
            chk = fhv_pkg::ST_TYPE;
        end else if (declared != avail) begin
            chk = fhv_pkg::ST_LENGTH;
        end else begin
            chk = fhv_pkg::ST_OK;
        end
    end

    assign commit = frame_acc && i_end_of_frame && (chk == fhv_pkg::ST_OK);

    // staging bank write
    assign pos     = r_count - CW'(HB);
    assign pos_w   = CMPW'(pos);
    assign wr_en   = frame_acc && (r_count >= CW'(HB)) && (pos_w < CMPW'(PAYLOAD_CAP));
    assign wr_addr = MAW'(r_bank ? pos_w : pos_w + CMPW'(PAYLOAD_CAP));

    // committed bank read
    assign ridx_w  = CMPW'(i_read_index);
    assign rd_hit  = (i_read_index < r_held_len) && (ridx_w < CMPW'(PAYLOAD_CAP));
    assign rd_addr = MAW'(r_bank ? ridx_w + CMPW'(PAYLOAD_CAP) : ridx_w);

    fhv_payload_store #(
        .DEPTH (DEPTH),
        .AW    (MAW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_en   (read_acc && rd_hit),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_p1 = '0;
        if (i_action == fhv_pkg::ACT_READ) begin
            n_p1.is_verdict     = 1'b0;
            n_p1.status         = fhv_pkg::ST_OK;
            n_p1.frame_type     = r_held_type;
            n_p1.shard_id       = r_held_shard;
            n_p1.payload_length = r_held_len;
            n_p1.zero_byte      = !rd_hit;
        end else begin
            n_p1.is_verdict = 1'b1;
            n_p1.status     = chk;
            n_p1.zero_byte  = 1'b1;
            if (chk == fhv_pkg::ST_OK) begin
                n_p1.frame_type     = n_hdr[33:32];
                n_p1.shard_id       = n_hdr[15:0];
                n_p1.payload_length = n_hdr[23:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_hdr        <= '0;
            r_bank       <= 1'b0;
            r_held_type  <= '0;
            r_held_shard <= '0;
            r_held_len   <= '0;
        end else if (frame_acc) begin
            r_hdr   <= n_hdr;
            r_count <= i_end_of_frame ? '0 : n_count;
            if (commit) begin
                r_bank       <= !r_bank;
                r_held_type  <= n_hdr[33:32];
                r_held_shard <= n_hdr[15:0];
                r_held_len   <= n_hdr[23:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && (read_acc || i_end_of_frame)) begin
                r_p1_valid <= 1'b1;
            end else if (p1_move) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1 <= n_p1;
        end
        if (p1_move) begin
            r_out      <= r_p1;
            r_out_byte <= r_p1.zero_byte ? 8'd0 : rd_data;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_is_frame_verdict  = r_out.is_verdict;
    assign o_status            = r_out.status;
    assign o_frame_type        = r_out.frame_type;
    assign o_shard_id          = r_out.shard_id;
    assign o_payload_length    = r_out.payload_length;
    assign o_payload_read_byte = r_out_byte;

    `ASSERT_IMPLY(a_ok_type, i_clk, i_rst_n,
        r_out_valid && r_out.is_verdict && r_out.status == fhv_pkg::ST_OK,
        r_out.frame_type == 2'd1 || r_out.frame_type == 2'd2)
    `ASSERT_IMPLY(a_reply_status, i_clk, i_rst_n,
        r_out_valid && !r_out.is_verdict, r_out.status == fhv_pkg::ST_OK)
    `ASSERT_NEXT(a_bank_flip, i_clk, i_rst_n, commit, r_bank != $past(r_bank))
    `ASSERT_NEXT(a_bank_hold, i_clk, i_rst_n, !commit, r_bank == $past(r_bank))
    `ASSERT_IMPLY(a_room, i_clk, i_rst_n, !r_p1_valid, o_in_ready)

endmodule
`default_nettype wire

@@ sim/tb_frame_header_validator.sv @@
module tb_frame_header_validator;

    localparam int PAYLOAD_CAP    = 248;
    localparam int COUNT_CEIL     = fhv_pkg::HEADER_BYTES + PAYLOAD_CAP + 1;
    localparam int TOTAL_ITEMS    = 1700;
    localparam int CALM_TAIL      = 250;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
        logic       eof;
        logic [7:0] ridx;
    } t_link_item;

    typedef struct packed {
        logic             is_verdict;
        fhv_pkg::t_status status;
        logic [1:0]       ftype;
        logic [15:0]      shard;
        logic [7:0]       plen;
        logic [7:0]       rbyte;
    } t_reply;

    typedef enum int {
        BREAK_MAGIC0, BREAK_MAGIC1, BREAK_VERSION, BREAK_TYPE, BREAK_LENGTH, BREAK_LENGTH_HI
    } t_fault;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = fhv_pkg::ACT_FRAME;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_frame = 1'b0;
    logic [7:0]  read_index = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        out_is_verdict;
    logic [2:0]  out_status;
    logic [1:0]  out_type;
    logic [15:0] out_shard;
    logic [7:0]  out_len;
    logic [7:0]  out_byte;

    t_link_item  items_to_send[$];
    t_reply      replies_due[$];
    t_link_item  on_wire;
    int          items_total = 0;
    int          items_sent = 0;
    int          in_gap = 0;
    int          out_stall = 0;
    int          mon_cycles = 0;
    int          errors = 0;
    int          quiet_cycles = 0;
    int          gen_len = 0;

    // predicted block state
    int unsigned frame_count = 0;
    logic [63:0] hdr_shift = '0;
    logic [7:0]  bank_mem [2*PAYLOAD_CAP] = '{default: 8'h00};
    logic        live_bank = 1'b0;
    logic [1:0]  kept_type = '0;
    logic [15:0] kept_shard = '0;
    logic [7:0]  kept_len = '0;

    frame_header_validator #(.PAYLOAD_CAP(PAYLOAD_CAP)) dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_action            (action),
        .i_data_byte         (data_byte),
        .i_end_of_frame      (end_of_frame),
        .i_read_index        (read_index),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_is_frame_verdict  (out_is_verdict),
        .o_status            (out_status),
        .o_frame_type        (out_type),
        .o_shard_id          (out_shard),
        .o_payload_length    (out_len),
        .o_payload_read_byte (out_byte)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] hdr_byte(input int pos);
        return hdr_shift[63 - 8*pos -: 8];
    endfunction

    function automatic fhv_pkg::t_status judge_frame(input int unsigned count);
        int unsigned avail;
        logic [15:0] declared;
        if (count < fhv_pkg::HEADER_BYTES) return fhv_pkg::ST_SHORT;
        avail = count - fhv_pkg::HEADER_BYTES;
        if (avail > PAYLOAD_CAP) return fhv_pkg::ST_TOO_LONG;
        if (hdr_byte(0) != fhv_pkg::MAGIC_0 || hdr_byte(1) != fhv_pkg::MAGIC_1)
            return fhv_pkg::ST_MAGIC;
        if (hdr_byte(2) != fhv_pkg::VERSION_ONE) return fhv_pkg::ST_VERSION;
        if (hdr_byte(3) < fhv_pkg::TYPE_MIN || hdr_byte(3) > fhv_pkg::TYPE_MAX)
            return fhv_pkg::ST_TYPE;
        declared = {hdr_byte(4), hdr_byte(5)};
        if (declared != avail) return fhv_pkg::ST_LENGTH;
        return fhv_pkg::ST_OK;
    endfunction

    task automatic predict_reply(input t_link_item it);
        t_reply           r;
        fhv_pkg::t_status st;
        int               pos;
        int               base;
        r = '0;
        if (it.action == fhv_pkg::ACT_READ) begin
            base = live_bank ? PAYLOAD_CAP : 0;
            r.is_verdict = 1'b0;
            r.status = fhv_pkg::ST_OK;
            r.ftype = kept_type;
            r.shard = kept_shard;
            r.plen = kept_len;
            if (it.ridx < kept_len) r.rbyte = bank_mem[base + it.ridx];
            replies_due.push_back(r);
        end else begin
            if (frame_count < fhv_pkg::HEADER_BYTES) begin
                hdr_shift = {hdr_shift[55:0], it.data};
            end else begin
                pos = frame_count - fhv_pkg::HEADER_BYTES;
                base = live_bank ? 0 : PAYLOAD_CAP;
                if (pos < PAYLOAD_CAP) bank_mem[base + pos] = it.data;
            end
            if (frame_count < COUNT_CEIL) frame_count++;
            if (it.eof) begin
                st = judge_frame(frame_count);
                frame_count = 0;
                r.is_verdict = 1'b1;
                r.status = st;
                if (st == fhv_pkg::ST_OK) begin
                    live_bank = !live_bank;
                    kept_type = hdr_shift[33:32];
                    kept_shard = hdr_shift[15:0];
                    kept_len = hdr_shift[23:16];
                    r.ftype = kept_type;
                    r.shard = kept_shard;
                    r.plen = kept_len;
                end
                replies_due.push_back(r);
            end
        end
    endtask

    // ---- stimulus builders
    function automatic logic [7:0] pick_index();
        if (gen_len > 0 && $urandom_range(0, 3) != 0) return 8'($urandom_range(0, gen_len - 1));
        return 8'($urandom_range(0, 247));
    endfunction

    task automatic add_frame_byte(input logic [7:0] b, input logic eof);
        t_link_item it;
        it.action = fhv_pkg::ACT_FRAME;
        it.data = b;
        it.eof = eof;
        it.ridx = 8'($urandom_range(0, 247));
        items_to_send.push_back(it);
    endtask

    task automatic add_read(input logic [7:0] idx);
        t_link_item it;
        it.action = fhv_pkg::ACT_READ;
        it.data = 8'($urandom_range(0, 255));
        it.eof = 1'($urandom_range(0, 1));   // ignored on reads
        it.ridx = idx;
        items_to_send.push_back(it);
    endtask

    task automatic add_frame(input logic [7:0] m0, m1, ver, ftype,
                             input logic [15:0] declared, shard,
                             input int n_payload, input int read_odds);
        logic [7:0] hdr [8];
        int total;
        hdr = '{m0, m1, ver, ftype, declared[15:8], declared[7:0], shard[15:8], shard[7:0]};
        total = fhv_pkg::HEADER_BYTES + n_payload;
        for (int k = 0; k < total; k++) begin
            if (read_odds > 0 && $urandom_range(1, read_odds) == 1) add_read(pick_index());
            add_frame_byte(k < fhv_pkg::HEADER_BYTES ? hdr[k] : 8'($urandom_range(0, 255)),
                           k == total - 1);
        end
    endtask

    task automatic add_good(input logic [7:0] ftype, input int n,
                            input logic [15:0] shard, input int read_odds);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, ftype, 16'(n),
                  shard, n, read_odds);
        gen_len = n;
    endtask

    task automatic add_short(input int n, input bit proper_start);
        logic [7:0] hdr [8];
        hdr = '{fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MIN,
                8'h00, 8'h00, 8'h00, 8'h00};
        for (int k = 0; k < n; k++)
            add_frame_byte(proper_start ? hdr[k] : 8'($urandom_range(0, 255)), k == n - 1);
    endtask

    task automatic add_broken_frame(input int n);
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [7:0]  ver;
        logic [7:0]  ftype;
        logic [15:0] declared;
        t_fault      fault;
        m0 = fhv_pkg::MAGIC_0;
        m1 = fhv_pkg::MAGIC_1;
        ver = fhv_pkg::VERSION_ONE;
        ftype = $urandom_range(0, 1) ? fhv_pkg::TYPE_MIN : fhv_pkg::TYPE_MAX;
        declared = 16'(n);
        fault = t_fault'($urandom_range(0, 5));
        case (fault)
            BREAK_MAGIC0:  m0 = m0 ^ 8'($urandom_range(1, 255));
            BREAK_MAGIC1:  m1 = m1 ^ 8'($urandom_range(1, 255));
            BREAK_VERSION: ver = ver ^ 8'($urandom_range(1, 255));
            BREAK_TYPE:    ftype = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(3, 255));
            BREAK_LENGTH: begin
                if (n > 0 && $urandom_range(0, 1)) declared = 16'(n - $urandom_range(1, n));
                else declared = 16'(n + $urandom_range(1, 10));
            end
            default:       declared[15:8] = 8'($urandom_range(1, 255));
        endcase
        add_frame(m0, m1, ver, ftype, declared, 16'($urandom_range(0, 65535)), n, 8);
    endtask

    task automatic build_directed();
        add_read(8'd0);
        add_read(8'd247);
        add_short(1, 1'b0);
        add_short(7, 1'b1);                       // right header start, one byte short
        add_good(fhv_pkg::TYPE_MIN, 0, 16'hFFFF, 0);       // header only
        add_read(8'd0);
        add_good(fhv_pkg::TYPE_MAX, 3, 16'h0000, 0);
        for (int k = 0; k < 4; k++) add_read(8'(k));
        add_frame(8'h50, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MIN,
                  16'd2, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, 8'h47, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MIN,
                  16'd2, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, 8'h00, fhv_pkg::TYPE_MIN,
                  16'd2, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, 8'hFF, fhv_pkg::TYPE_MIN,
                  16'd2, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, 8'h00,
                  16'd2, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, 8'h03,
                  16'd2, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, 8'hFF,
                  16'd2, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MAX,
                  16'd3, 16'h1234, 2, 0);
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MAX,
                  16'h0102, 16'h1234, 2, 0);
        for (int k = 0; k < 3; k++) add_read(8'(k));
        add_good(fhv_pkg::TYPE_MIN, PAYLOAD_CAP, 16'hA55A, 40);
        add_read(8'd247);
        add_read(8'd0);
        add_read(8'd128);
        // one past the cap, then with a bad magic too: size check comes first
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MIN,
                  16'd249, 16'h0001, 249, 0);
        add_frame(8'h00, 8'h00, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MIN,
                  16'd249, 16'h0001, 249, 0);
        // well past the saturation point of the byte counter
        add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE, fhv_pkg::TYPE_MIN,
                  16'd300, 16'h0002, 300, 0);
        add_short(3, 1'b1);
        add_read(8'd247);
        add_read(8'd100);
        add_good(fhv_pkg::TYPE_MAX, 5, 16'hAAAA, 2);
    endtask

    task automatic build_random();
        int pick;
        int n;
        while (items_to_send.size() < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(200, PAYLOAD_CAP)
                                             : $urandom_range(0, 24);
            if (pick < 60) begin
                add_good($urandom_range(0, 1) ? fhv_pkg::TYPE_MIN : fhv_pkg::TYPE_MAX, n,
                         16'($urandom_range(0, 65535)), 6);
                repeat ($urandom_range(0, 3)) add_read(pick_index());
            end else if (pick < 78) begin
                add_broken_frame(n);
            end else if (pick < 88) begin
                add_short($urandom_range(1, 7), 1'($urandom_range(0, 1)));
            end else if (pick < 90) begin
                n = $urandom_range(PAYLOAD_CAP + 1, PAYLOAD_CAP + 16);
                add_frame(fhv_pkg::MAGIC_0, fhv_pkg::MAGIC_1, fhv_pkg::VERSION_ONE,
                          fhv_pkg::TYPE_MIN, 16'(n), 16'($urandom_range(0, 65535)), n, 20);
            end else begin
                repeat ($urandom_range(1, 6)) add_read(pick_index());
            end
        end
    endtask

    // ---- input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_reply(on_wire);
                items_sent++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (items_to_send.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (items_total - items_sent >= CALM_TAIL
                             && (items_sent / 150) % 4 != 3
                             && $urandom_range(0, 11) == 0) begin
                    in_gap = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end else begin
                    on_wire = items_to_send.pop_front();
                    in_valid <= 1'b1;
                    action <= on_wire.action;
                    data_byte <= on_wire.data;
                    end_of_frame <= on_wire.eof;
                    read_index <= on_wire.ridx;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // ---- result monitor
    always @(posedge clk) begin : result_mon
        t_reply want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            mon_cycles++;
            if (out_valid && out_ready) begin
                if (replies_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result with nothing due: verdict %0b status %0d",
                                 out_is_verdict, out_status);
                end else begin
                    want = replies_due.pop_front();
                    check_field("is_frame_verdict", 16'(want.is_verdict), 16'(out_is_verdict));
                    check_field("status", 16'(want.status), 16'(out_status));
                    check_field("frame_type", 16'(want.ftype), 16'(out_type));
                    check_field("shard_id", want.shard, out_shard);
                    check_field("payload_length", 16'(want.plen), 16'(out_len));
                    check_field("payload_read_byte", 16'(want.rbyte), 16'(out_byte));
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else if (items_total - items_sent >= CALM_TAIL
                         && (mon_cycles / 256) % 4 != 1
                         && $urandom_range(0, 11) == 0) begin
                out_stall = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ---- watchdog: cycles with no item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_frame_header_validator: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        build_directed();
        build_random();
        items_total = items_to_send.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (items_sent < items_total);
        while (replies_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("tb_frame_header_validator: done, clean");
        end else begin
            $display("tb_frame_header_validator: done, errors");
        end
        $finish;
    end

endmodule
